// ===== rtl/ssel_pkg.sv =====
package ssel_pkg;

    localparam int MAX_PER_LINE_DEF = 10;
    localparam int LINE_OFFSET      = 16;
    localparam int HEIGHT_SHORT     = 8;
    localparam int HEIGHT_TALL      = 16;

    typedef struct packed {
        logic [7:0] y;
        logic [7:0] x;
        logic [7:0] tile;
        logic [7:0] flags;
    } t_entry;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctl;

endpackage

// ===== rtl/ssel_cell.sv =====
module ssel_cell
    import ssel_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occ,
    input  t_entry    i_new_word,
    input  t_entry    i_prev_word,
    input  logic      i_prev_keep,
    input  t_entry    i_next_word,
    output t_entry    o_word,
    output logic      o_keep
);

    t_entry r_word;
    t_entry n_word;

    assign o_keep = i_occ && (r_word.x <= i_new_word.x);
    assign o_word = r_word;

    always_comb begin
        n_word = r_word;
        if (i_ctl.pop) begin
            n_word = i_next_word;
        end else if (i_ctl.ins && !o_keep) begin
            n_word = i_prev_keep ? i_new_word : i_prev_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

endmodule

// ===== rtl/scanline_sprite_selector_top.sv =====
// Scan phase: one entry beat per cycle, ready stays high while entries stream in.
// The first result beat is registered once the state has moved to emission and the output register is free, then one
// result beat per cycle (a single empty beat when nothing is selected) while out ready.
// Input ready drops after the last entry beat and returns once the last of the N selected beats (N the selected
// count; the empty beat when N is 0) is loaded; a receiver that holds off result beats keeps it low longer.
// Reset (i_rst_n low, synchronous) clears count, state, output valid and the tall setting r_tall.
module scanline_sprite_selector_top
    import ssel_pkg::*;
#(
    parameter int MAX_PER_LINE = MAX_PER_LINE_DEF
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_entry_y,
    input  logic [7:0] i_entry_x,
    input  logic [7:0] i_entry_tile,
    input  logic [7:0] i_entry_flags,
    input  logic [7:0] i_scan_line,
    input  logic       i_last_entry,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_found,
    output logic [7:0] o_sprite_y,
    output logic [7:0] o_sprite_x,
    output logic [7:0] o_sprite_tile,
    output logic [7:0] o_sprite_flags,
    output logic       o_last_sprite
);

    localparam int CW = $clog2(MAX_PER_LINE + 1);

    localparam logic ST_SCAN = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic          r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_tall;
    logic          r_out_valid;
    logic          r_found;
    t_entry        r_out;
    logic          r_last;

    logic          in_acc, out_free, take, pop, empty_out;
    logic [8:0]    target, y_end;
    t_entry        new_word;
    t_cell_ctl     ctl;

    t_entry        words [MAX_PER_LINE];
    logic          keeps [MAX_PER_LINE];

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_SCAN);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    assign new_word = '{y: i_entry_y, x: i_entry_x, tile: i_entry_tile, flags: i_entry_flags};
    assign target   = {1'b0, i_scan_line} + 9'(LINE_OFFSET);
    assign y_end    = {1'b0, i_entry_y} + (r_tall ? 9'(HEIGHT_TALL) : 9'(HEIGHT_SHORT));

    assign take = in_acc && (i_entry_x != 8'd0) && (r_count < CW'(MAX_PER_LINE))
                  && ({1'b0, i_entry_y} <= target) && (y_end > target);

    assign pop       = (r_state == ST_EMIT) && (r_count != '0) && out_free;
    assign empty_out = (r_state == ST_EMIT) && (r_count == '0) && out_free;

    assign ctl = '{ins: take, pop: pop};

    for (genvar g = 0; g < MAX_PER_LINE; g++) begin : g_cell
        ssel_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_occ       (CW'(g) < r_count),
            .i_new_word  (new_word),
            .i_prev_word ((g == 0) ? new_word : words[(g == 0) ? 0 : g - 1]),
            .i_prev_keep ((g == 0) ? 1'b1 : keeps[(g == 0) ? 0 : g - 1]),
            .i_next_word ((g == MAX_PER_LINE - 1) ? t_entry'('0)
                          : words[(g == MAX_PER_LINE - 1) ? g : g + 1]),
            .o_word      (words[g]),
            .o_keep      (keeps[g])
        );
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (r_state)
            ST_SCAN: begin
                if (take) begin
                    n_count = r_count + CW'(1);
                end
                if (in_acc && i_last_entry) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (pop) begin
                    n_count = r_count - CW'(1);
                    if (r_count == CW'(1)) begin
                        n_state = ST_SCAN;
                    end
                end else if (empty_out) begin
                    n_state = ST_SCAN;
                end
            end
            default: begin
                n_state = ST_SCAN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SCAN;
            r_count     <= '0;
            r_tall      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tall <= i_cfg_data;
            end
            if (pop || empty_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_found <= 1'b1;
            r_out   <= words[0];
            r_last  <= (r_count == CW'(1));
        end else if (empty_out) begin
            r_found <= 1'b0;
            r_out   <= '0;
            r_last  <= 1'b1;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_sprite_y     = r_out.y;
    assign o_sprite_x     = r_out.x;
    assign o_sprite_tile  = r_out.tile;
    assign o_sprite_flags = r_out.flags;
    assign o_last_sprite  = r_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PER_LINE))
        else $error("sprite count beyond capacity");

    a_last_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_last_entry |=> r_state == ST_EMIT)
        else $error("last entry beat did not start emission");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_last_sprite)
        else $error("empty result not marked last");

    a_no_take_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT |-> !take)
        else $error("entry taken during emission");

endmodule

// ===== bench/scanline_sprite_selector_top_test.sv =====
module scanline_sprite_selector_top_test
    import ssel_pkg::*;
;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 200;

    typedef struct packed {
        logic   found;
        t_entry spr;
        logic   is_last;
    } t_sprite_beat;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_data;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_entry_y;
    logic [7:0] i_entry_x;
    logic [7:0] i_entry_tile;
    logic [7:0] i_entry_flags;
    logic [7:0] i_scan_line;
    logic       i_last_entry;
    logic       o_out_valid;
    logic       i_out_ready;
    logic       o_found;
    logic [7:0] o_sprite_y;
    logic [7:0] o_sprite_x;
    logic [7:0] o_sprite_tile;
    logic [7:0] o_sprite_flags;
    logic       o_last_sprite;

    t_entry       chosen_sprites [MAX_PER_LINE_DEF];
    int           chosen_num;
    logic         tall_cfg;
    t_sprite_beat pending_sprites[$];
    t_sprite_beat want;
    int           mismatches;
    int           send_idle;
    int           recv_idle;
    int           cycle_count;
    bit           hold_active;
    event         hold_go;

    scanline_sprite_selector_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_entry_y      (i_entry_y),
        .i_entry_x      (i_entry_x),
        .i_entry_tile   (i_entry_tile),
        .i_entry_flags  (i_entry_flags),
        .i_scan_line    (i_scan_line),
        .i_last_entry   (i_last_entry),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_found        (o_found),
        .o_sprite_y     (o_sprite_y),
        .o_sprite_x     (o_sprite_x),
        .o_sprite_tile  (o_sprite_tile),
        .o_sprite_flags (o_sprite_flags),
        .o_last_sprite  (o_last_sprite)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always begin
        @(hold_go);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= !hold_active && ($urandom_range(99) >= recv_idle);
    end

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_sprites.size() == 0) begin
                $error("sprite beat with nothing expected");
                mismatches++;
            end else begin
                want = pending_sprites.pop_front();
                check_field("found", want.found, o_found);
                check_field("sprite_y", want.spr.y, o_sprite_y);
                check_field("sprite_x", want.spr.x, o_sprite_x);
                check_field("sprite_tile", want.spr.tile, o_sprite_tile);
                check_field("sprite_flags", want.spr.flags, o_sprite_flags);
                check_field("last_sprite", want.is_last, o_last_sprite);
            end
        end
    end

    task automatic update_line_selection(t_entry e, logic [7:0] line, logic is_last);
        int           height;
        int           target;
        int           pos;
        t_sprite_beat beat;
        height = tall_cfg ? HEIGHT_TALL : HEIGHT_SHORT;
        target = line + LINE_OFFSET;
        if (e.x != 0 && chosen_num < MAX_PER_LINE_DEF && e.y <= target
                && e.y + height > target) begin
            pos = chosen_num;
            while (pos > 0 && chosen_sprites[pos - 1].x > e.x) begin
                chosen_sprites[pos] = chosen_sprites[pos - 1];
                pos--;
            end
            chosen_sprites[pos] = e;
            chosen_num++;
        end
        if (is_last) begin
            if (chosen_num == 0) begin
                beat = '0;
                beat.is_last = 1'b1;
                pending_sprites = {pending_sprites, beat};
            end
            for (int k = 0; k < chosen_num; k++) begin
                beat.found = 1'b1;
                beat.spr = chosen_sprites[k];
                beat.is_last = (k == chosen_num - 1);
                pending_sprites = {pending_sprites, beat};
            end
            chosen_num = 0;
        end
    endtask

    task automatic send_entry(t_entry e, logic [7:0] line, logic is_last);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_entry_y     <= e.y;
        i_entry_x     <= e.x;
        i_entry_tile  <= e.tile;
        i_entry_flags <= e.flags;
        i_scan_line   <= line;
        i_last_entry  <= is_last;
        do @(posedge i_clk); while (!o_in_ready);
        update_line_selection(e, line, is_last);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_sprites.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tall(logic value);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tall_cfg = value;
    endtask

    function automatic t_entry ent(int y, int x, int tile, int flags);
        t_entry e;
        e.y = 8'(y);
        e.x = 8'(x);
        e.tile = 8'(tile);
        e.flags = 8'(flags);
        return e;
    endfunction

    function automatic t_entry make_entry(logic [7:0] line, int hit_pct);
        int height;
        int yc;
        height = tall_cfg ? HEIGHT_TALL : HEIGHT_SHORT;
        if ($urandom_range(99) < hit_pct) begin
            yc = int'(line) + LINE_OFFSET - int'($urandom_range(height - 1));
        end else begin
            case ($urandom_range(2))
                0: yc = int'(line) + LINE_OFFSET + int'($urandom_range(1, 3));
                1: yc = int'(line) + LINE_OFFSET - height - int'($urandom_range(2));
                default: yc = int'($urandom_range(255));
            endcase
        end
        if (yc < 0 || yc > 255)
            yc = $urandom_range(255);
        case ($urandom_range(9))
            0: return ent(yc, 0, $urandom_range(255), $urandom_range(255));
            1, 2, 3: return ent(yc, $urandom_range(1, 6), $urandom_range(255),
                                $urandom_range(255));
            default: return ent(yc, $urandom_range(1, 255), $urandom_range(255),
                                $urandom_range(255));
        endcase
    endfunction

    task automatic send_scan(int len, int hit_pct, logic [7:0] line);
        logic [7:0] item_line;
        for (int k = 0; k < len; k++) begin
            item_line = ($urandom_range(99) < 8) ? 8'($urandom_range(255)) : line;
            send_entry(make_entry(item_line, hit_pct), item_line, k == len - 1);
        end
    endtask

    task automatic test_short_edges();
        send_entry(ent(16, 255, 255, 255), 0, 1'b0);
        send_entry(ent(9, 3, 8'h11, 8'h22), 0, 1'b0);
        send_entry(ent(8, 4, 8'h33, 8'h44), 0, 1'b0);
        send_entry(ent(17, 5, 8'h55, 8'h66), 0, 1'b0);
        send_entry(ent(12, 0, 8'h77, 8'h88), 0, 1'b0);
        send_entry(ent(10, 3, 8'haa, 8'hbb), 0, 1'b0);
        send_entry(ent(16, 1, 0, 0), 0, 1'b1);
    endtask

    task automatic test_empty_scans();
        send_entry(ent(0, 0, 0, 0), 100, 1'b1);
        send_entry(ent(255, 9, 8'h5a, 8'ha5), 255, 1'b1);
    endtask

    task automatic test_line_mismatch();
        send_entry(ent(255, 7, 8'h01, 8'h02), 247, 1'b0);
        send_entry(ent(16, 200, 8'h03, 8'h04), 0, 1'b1);
    endtask

    task automatic test_full_line();
        for (int k = 0; k < 12; k++)
            send_entry(ent(60, 120 - 10 * k, k, 8'hf0 + k), 50, k == 11);
    endtask

    task automatic test_tall_edges();
        write_tall(1'b1);
        send_entry(ent(1, 8, 8'h10, 8'h20), 0, 1'b0);
        send_entry(ent(0, 9, 8'h30, 8'h40), 0, 1'b0);
        send_entry(ent(16, 8, 8'h50, 8'h60), 0, 1'b0);
        send_entry(ent(255, 2, 8'h70, 8'h80), 247, 1'b1);
    endtask

    task automatic test_random_traffic(int n_items, logic tall, int s_idle, int r_idle);
        int         sent;
        int         len;
        logic [7:0] line;
        write_tall(tall);
        send_idle = s_idle;
        recv_idle = r_idle;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 14);
            case ($urandom_range(7))
                0: line = 8'd0;
                1: line = 8'($urandom_range(235, 255));
                default: line = 8'($urandom_range(255));
            endcase
            send_scan(len, $urandom_range(20, 95), line);
            sent += len;
        end
    endtask

    task automatic test_receiver_hold();
        write_tall(1'b1);
        send_idle = 0;
        recv_idle = 0;
        -> hold_go;
        send_scan(12, 95, 80);
        send_scan(10, 90, 30);
        send_scan(8, 90, 200);
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 1'b0;
        i_in_valid    = 1'b0;
        i_entry_y     = '0;
        i_entry_x     = '0;
        i_entry_tile  = '0;
        i_entry_flags = '0;
        i_scan_line   = '0;
        i_last_entry  = 1'b0;
        i_out_ready   = 1'b0;
        cycle_count   = 0;
        mismatches    = 0;
        chosen_num    = 0;
        tall_cfg      = 1'b0;
        send_idle     = 35;
        recv_idle     = 55;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_short_edges();
        test_empty_scans();
        test_line_mismatch();
        test_full_line();
        test_tall_edges();
        test_random_traffic(30, 1'b0, 35, 55);
        test_random_traffic(30, 1'b1, 55, 35);
        test_random_traffic(30, 1'b0, 0, 0);
        test_receiver_hold();
        settle();

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== scanline_sprite_selector_top.f =====
rtl/ssel_pkg.sv
rtl/ssel_cell.sv
rtl/scanline_sprite_selector_top.sv
bench/scanline_sprite_selector_top_test.sv
